@@ design/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// pre holds at one edge, post must hold at the next edge
`define MF_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");

// pre and post hold at the same edge
`define MF_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: same-cycle implication");

`endif

@@ design/mf_pkg.sv @@
// Package for the median filter: types, register codes and defaults.
package mf_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_RADIUS_DEF = 3;
   localparam int PIXEL_BITS_DEF = 8;

   localparam int ROW_BITS   = 12;
   localparam int HEIGHT_MAX = 4096;
   localparam int FW_BITS    = 11;
   localparam int FH_BITS    = 13;
   localparam int WR_BITS    = 2;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 13;

   localparam logic [FW_BITS-1:0] FW_RESET = FW_BITS'(640);
   localparam logic [FH_BITS-1:0] FH_RESET = FH_BITS'(480);
   localparam logic [WR_BITS-1:0] WR_RESET = WR_BITS'(1);

   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_RADIUS = 2'd2;

   typedef struct packed {
      logic [7:0] pixel_in;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [7:0]  median_value;
      logic [11:0] center_row;
      logic [9:0]  center_col;
   } rsp_type;

endpackage

@@ design/mf_ram.sv @@
// Simple dual-port RAM with registered read.
module mf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ design/mf_cell.sv @@
// One cell of the insertion sorting chain.
module mf_cell #(
   parameter int PIXEL_BITS = 8
) (
   input  logic                  clock,
   input  logic                  clear,
   input  logic                  insert,
   input  logic [PIXEL_BITS-1:0] din,
   input  logic [PIXEL_BITS-1:0] left,
   output logic [PIXEL_BITS-1:0] value
);
   logic [PIXEL_BITS-1:0] value_ff;

   always_ff @(posedge clock) begin
      if (clear) begin
         value_ff <= '1;
      end else if (insert && (din < value_ff)) begin
         value_ff <= (din < left) ? left : din;
      end
   end

   assign value = value_ff;
endmodule

@@ design/mf_sorter.sv @@
// Chain of sorting cells with median selection by radius.
module mf_sorter #(
   parameter int PIXEL_BITS = 8,
   parameter int MAX_RADIUS = 3
) (
   input  logic                              clock,
   input  logic                              clear,
   input  logic                              insert,
   input  logic [PIXEL_BITS-1:0]             din,
   input  logic [$clog2(MAX_RADIUS+1)-1:0]   radius,
   output logic [PIXEL_BITS-1:0]             median
);
   localparam int SIDE = 2 * MAX_RADIUS + 1;
   localparam int NW   = SIDE * SIDE;
   localparam int RW   = $clog2(MAX_RADIUS + 1);

   logic [PIXEL_BITS-1:0] val [NW];

   for (genvar k = 0; k < NW; k++) begin : g_cell
      logic [PIXEL_BITS-1:0] left;
      if (k == 0) begin : g_first
         assign left = '0;
      end else begin : g_rest
         assign left = val[k-1];
      end
      mf_cell #(.PIXEL_BITS(PIXEL_BITS)) u_cell (
         .clock  (clock),
         .clear  (clear),
         .insert (insert),
         .din    (din),
         .left   (left),
         .value  (val[k])
      );
   end

   always_comb begin
      median = val[0];
      for (int rr = 1; rr <= MAX_RADIUS; rr++) begin
         if (radius == RW'(rr)) begin
            median = val[2 * rr * (rr + 1)];
         end
      end
   end
endmodule

@@ design/median_filter_2d.sv @@
// Top level of the streaming square-window median filter.
// Input channel req_*: one pixel per transaction in raster order; frame_start
// places the pixel at row 0, column 0. Result channel rsp_*: one median per
// pixel that completes an interior window, with the window center position.
// Border positions give no result. Configuration channel csr_*: frame width,
// frame height and window radius R; csr_ready is always high; write only
// while the block is idle.
// Flow: an accepted pixel passes ST_LOAD and, if it completes a window,
// ST_SNAP, ST_SORT and ST_DONE, where the result is written to the output
// register; a pixel that completes no window frees the input after ST_LOAD.
// One pixel is in work at a time; the sorting chain takes one window pixel
// per cycle. Line stores are 2*MAX_RADIUS RAMs of MAX_WIDTH pixels.
// Reset clears the position counters, the state and the output valid flag
// and loads the default geometry; line stores are not cleared.
// A stalled result stays in the output register; the next pixel is still
// accepted and processed, and the block holds before its own result until
// the output register is free.
module median_filter_2d #(
   parameter int MAX_WIDTH  = mf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_RADIUS = mf_pkg::MAX_RADIUS_DEF,
   parameter int PIXEL_BITS = mf_pkg::PIXEL_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  mf_pkg::req_type                     req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output mf_pkg::rsp_type                     rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mf_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [mf_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import mf_pkg::*;

   localparam int SIDE  = 2 * MAX_RADIUS + 1;
   localparam int LINES = 2 * MAX_RADIUS;
   localparam int NW    = SIDE * SIDE;
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_RADIUS + 1);
   localparam int RX    = (RW > WR_BITS) ? RW : WR_BITS;
   localparam int LW    = (LINES > 2) ? $clog2(LINES) : 1;
   localparam int LNB   = $clog2(LINES + 1);
   localparam int WW    = (CW + 1 > FW_BITS) ? CW + 1 : FW_BITS;
   localparam int CNW   = $clog2(NW + 1);
   localparam int PB    = PIXEL_BITS;

   typedef enum logic [2:0] {ST_IDLE, ST_LOAD, ST_SNAP, ST_SORT, ST_DONE} state_type;

   state_type state_ff;

   logic [FW_BITS-1:0]  fw_ff;
   logic [FH_BITS-1:0]  fh_ff;
   logic [WR_BITS-1:0]  wr_ff;

   logic [ROW_BITS-1:0] row_ff;
   logic [CW-1:0]       col_ff;
   logic [LW-1:0]       mod_ff [MAX_RADIUS];

   logic [ROW_BITS-1:0] cur_row_ff;
   logic [CW-1:0]       cur_col_ff;
   logic [LW-1:0]       cur_rm_ff;
   logic [PB-1:0]       pix_ff;
   logic [CNW-1:0]      cnt_ff;

   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   logic [PB-1:0]       win_ff  [SIDE][SIDE];
   logic [PB-1:0]       snap_ff [NW];
   logic [PB-1:0]       cand    [MAX_RADIUS][NW];
   logic [PB-1:0]       snap_in [NW];
   logic [PB-1:0]       rd_data [LINES];

   logic [CW:0]         w_eff;
   logic [FH_BITS-1:0]  h_eff;
   logic [RW-1:0]       r_eff;
   logic [LNB-1:0]      lines_eff;
   logic [CNW-1:0]      n_eff;

   logic [CW-1:0]       c0;
   logic [FH_BITS-1:0]  r0t;
   logic [CW:0]         c1t;
   logic [FH_BITS-1:0]  r1t;
   logic [LW-1:0]       m0 [MAX_RADIUS];
   logic [LW-1:0]       m1 [MAX_RADIUS];
   logic [LW-1:0]       rm0;

   logic                req_acc;
   logic                out_free;
   logic                emit;
   logic                sort_clear;
   logic                sort_insert;
   logic [PB-1:0]       median;

   // effective geometry
   always_comb begin
      logic [WW-1:0] fw_x;
      logic [RX-1:0] wr_x;
      fw_x = WW'(fw_ff);
      wr_x = RX'(wr_ff);
      if (fw_x == '0) begin
         w_eff = (CW+1)'(1);
      end else if (fw_x > WW'(MAX_WIDTH)) begin
         w_eff = (CW+1)'(MAX_WIDTH);
      end else begin
         w_eff = (CW+1)'(fw_x);
      end
      if (fh_ff == '0) begin
         h_eff = FH_BITS'(1);
      end else if (fh_ff > FH_BITS'(HEIGHT_MAX)) begin
         h_eff = FH_BITS'(HEIGHT_MAX);
      end else begin
         h_eff = fh_ff;
      end
      if (wr_x == '0) begin
         r_eff = RW'(1);
      end else if (wr_x > RX'(MAX_RADIUS)) begin
         r_eff = RW'(MAX_RADIUS);
      end else begin
         r_eff = RW'(wr_x);
      end
      lines_eff = LNB'({r_eff, 1'b0});
      n_eff = CNW'(9);
      for (int rr = 1; rr <= MAX_RADIUS; rr++) begin
         if (r_eff == RW'(rr)) begin
            n_eff = CNW'((2 * rr + 1) * (2 * rr + 1));
         end
      end
   end

   // position counters before and after this pixel
   always_comb begin
      logic          cw0;
      logic          rw0;
      logic          cw1;
      logic          rw1;
      logic [LW-1:0] m;
      c0  = req_data.frame_start ? '0 : col_ff;
      r0t = req_data.frame_start ? '0 : FH_BITS'(row_ff);
      cw0 = ({1'b0, c0} >= w_eff);
      if (cw0) begin
         c0  = '0;
         r0t = r0t + FH_BITS'(1);
      end
      rw0 = (r0t >= h_eff);
      if (rw0) begin
         r0t = '0;
      end
      c1t = {1'b0, c0} + (CW+1)'(1);
      cw1 = (c1t >= w_eff);
      r1t = r0t;
      if (cw1) begin
         c1t = '0;
         r1t = r0t + FH_BITS'(1);
      end
      rw1 = (r1t >= h_eff);
      if (rw1) begin
         r1t = '0;
      end
      rm0 = '0;
      for (int rr = 0; rr < MAX_RADIUS; rr++) begin
         m = req_data.frame_start ? '0 : mod_ff[rr];
         if (cw0) begin
            m = (m == LW'(2 * (rr + 1) - 1)) ? '0 : m + LW'(1);
         end
         if (rw0) begin
            m = '0;
         end
         m0[rr] = m;
         if (cw1) begin
            m = (m == LW'(2 * (rr + 1) - 1)) ? '0 : m + LW'(1);
         end
         if (rw1) begin
            m = '0;
         end
         m1[rr] = m;
         if (r_eff == RW'(rr + 1)) begin
            rm0 = m0[rr];
         end
      end
   end

   assign req_acc   = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = (cur_row_ff >= ROW_BITS'(lines_eff)) &&
                      ((CW+1)'(cur_col_ff) >= (CW+1)'(lines_eff));
   assign csr_ready = 1'b1;

   for (genvar k = 0; k < LINES; k++) begin : g_line
      mf_ram #(.WIDTH(PB), .DEPTH(MAX_WIDTH)) u_line (
         .clock   (clock),
         .wr_en   ((state_ff == ST_LOAD) && (cur_rm_ff == LW'(k))),
         .wr_addr (cur_col_ff),
         .wr_data (pix_ff),
         .rd_addr (c0),
         .rd_data (rd_data[k])
      );
   end

   for (genvar rr = 1; rr <= MAX_RADIUS; rr++) begin : g_rad
      localparam int S = 2 * rr + 1;
      for (genvar k = 0; k < NW; k++) begin : g_k
         if (k < S * S) begin : g_on
            assign cand[rr-1][k] = win_ff[k / S][SIDE - S + k % S];
         end else begin : g_off
            assign cand[rr-1][k] = '0;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < NW; k++) begin
         snap_in[k] = cand[0][k];
         for (int rr = 1; rr <= MAX_RADIUS; rr++) begin
            if (r_eff == RW'(rr)) begin
               snap_in[k] = cand[rr-1][k];
            end
         end
      end
   end

   // window shift and snapshot shift line
   always_ff @(posedge clock) begin
      logic [LW:0] sel;
      if (state_ff == ST_LOAD) begin
         for (int i = 0; i < SIDE; i++) begin
            for (int j = 0; j < SIDE - 1; j++) begin
               win_ff[i][j] <= win_ff[i][j+1];
            end
         end
         for (int i = 0; i < LINES; i++) begin
            sel = (LW+1)'(cur_rm_ff) + (LW+1)'(i);
            if (sel >= (LW+1)'(lines_eff)) begin
               sel = sel - (LW+1)'(lines_eff);
            end
            if (LNB'(i) < lines_eff) begin
               win_ff[i][SIDE-1] <= rd_data[sel[LW-1:0]];
            end
         end
         for (int i = 0; i < SIDE; i++) begin
            if (LNB'(i) == lines_eff) begin
               win_ff[i][SIDE-1] <= pix_ff;
            end
         end
      end
      if (state_ff == ST_SNAP) begin
         snap_ff <= snap_in;
      end else if (state_ff == ST_SORT) begin
         for (int k = 0; k < NW - 1; k++) begin
            snap_ff[k] <= snap_ff[k+1];
         end
      end
   end

   assign sort_clear  = (state_ff == ST_SNAP);
   assign sort_insert = (state_ff == ST_SORT);

   mf_sorter #(.PIXEL_BITS(PB), .MAX_RADIUS(MAX_RADIUS)) u_sorter (
      .clock  (clock),
      .clear  (sort_clear),
      .insert (sort_insert),
      .din    (snap_ff[0]),
      .radius (r_eff),
      .median (median)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fw_ff        <= FW_RESET;
         fh_ff        <= FH_RESET;
         wr_ff        <= WR_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
         cnt_ff       <= '0;
         for (int rr = 0; rr < MAX_RADIUS; rr++) begin
            mod_ff[rr] <= '0;
         end
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_FRAME_WIDTH:   fw_ff <= csr_data[FW_BITS-1:0];
               CSR_FRAME_HEIGHT:  fh_ff <= csr_data[FH_BITS-1:0];
               CSR_WINDOW_RADIUS: wr_ff <= csr_data[WR_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  row_ff     <= r1t[ROW_BITS-1:0];
                  col_ff     <= c1t[CW-1:0];
                  mod_ff     <= m1;
                  cur_row_ff <= r0t[ROW_BITS-1:0];
                  cur_col_ff <= c0;
                  cur_rm_ff  <= rm0;
                  pix_ff     <= req_data.pixel_in[PB-1:0];
                  state_ff   <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               state_ff <= emit ? ST_SNAP : ST_IDLE;
            end
            ST_SNAP: begin
               cnt_ff   <= '0;
               state_ff <= ST_SORT;
            end
            ST_SORT: begin
               cnt_ff <= cnt_ff + CNW'(1);
               if (cnt_ff == n_eff - CNW'(1)) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff             <= 1'b1;
                  rsp_data_ff.median_value <= 8'(median);
                  rsp_data_ff.center_row   <= cur_row_ff - ROW_BITS'(r_eff);
                  rsp_data_ff.center_col   <= 10'(cur_col_ff - CW'(r_eff));
                  state_ff                 <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

@@ design/mf_checker.sv @@
// Port-level checker for the median filter, bound to the top level.
`include "assert_macros.svh"
module mf_checker (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input mf_pkg::rsp_type rsp_data,
   input logic            csr_valid,
   input logic            csr_ready
);
   `MF_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)
   `MF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `MF_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && !req_stall)
   `MF_ASSERT_IMPLY(a_csr_ready, clock, reset, csr_valid, csr_ready)
endmodule

bind median_filter_2d mf_checker u_mf_checker (.*);
